/* rtl/slxfr_pkg.sv */
// ----------------------------------------------------------------------------
// slxfr_pkg
// Shared types and constants for the sync/length/xor frame receiver.
// ----------------------------------------------------------------------------
package slxfr_pkg;

    localparam int DEF_FRAME_BUFFER_BYTES = 64;
    localparam int DEF_POSE_BYTE_COUNT    = 6;

    // pose field on the output stream is always six bytes
    localparam int POSE_W = 48;

    localparam logic [7:0] SYNC_ONE_RESET   = 8'hA7;
    localparam logic [7:0] SYNC_TWO_RESET   = 8'h7A;
    localparam logic [7:0] SYNC_THREE_RESET = 8'h72;

    // bytes ahead of the checksum byte and payload: three sync bytes and the length byte
    localparam int HEADER_BYTES = 4;

    typedef enum logic [1:0] {
        CFG_SYNC_ONE   = 2'd0,
        CFG_SYNC_TWO   = 2'd1,
        CFG_SYNC_THREE = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] one;
        logic [7:0] two;
        logic [7:0] three;
    } sync_cfg_t;

    typedef struct packed {
        logic              frame_ok;
        logic [POSE_W-1:0] pose_bytes;
    } result_t;

endpackage

/* rtl/sync_length_xor_frame_receiver.sv */
// ----------------------------------------------------------------------------
// sync_length_xor_frame_receiver
// Byte-stream framer: sync header, length, xor checksum, pose capture.
// ----------------------------------------------------------------------------
// Takes one received byte per clock cycle while the input is not stalled.
// Each byte sits in an input register while the frame logic (sync compare,
// length check, xor and payload capture) works on it, and a frame's result
// is then written to the output register, where the sink can take it.
// Bytes that end no frame never wait on the sink; the input stalls only
// when a frame ends while the previous result is still held on the output.
// One result per good or bad-checksum frame; dropped sync or length bytes
// give none.
module sync_length_xor_frame_receiver
    import slxfr_pkg::*;
#(
    parameter int FRAME_BUFFER_BYTES = DEF_FRAME_BUFFER_BYTES,
    parameter int POSE_BYTE_COUNT    = DEF_POSE_BYTE_COUNT
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] rx_byte

    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [POSE_W-1:0] m_axis_tdata,   // [47:0] pose_bytes
    output logic [0:0]        m_axis_tuser,   // [0] frame_ok

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       s_accept;
    logic       advance;
    logic       produce;
    logic       out_free;
    sync_cfg_t  sync_cfg;
    result_t    parse_result;
    result_t    out_result;

    assign cfg_ready = 1'b1;

    slxfr_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .sync_cfg (sync_cfg)
    );

    // only a frame-ending byte needs room in the result register
    assign out_free      = !m_axis_tvalid || m_axis_tready;
    assign advance       = in_valid_reg && (!produce || out_free);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    slxfr_parser #(
        .FRAME_BUFFER_BYTES (FRAME_BUFFER_BYTES),
        .POSE_BYTE_COUNT    (POSE_BYTE_COUNT)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .sync_cfg (sync_cfg),
        .step     (advance),
        .rx_byte  (in_byte_reg),
        .produce  (produce),
        .result   (parse_result)
    );

    slxfr_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && produce),
        .load_data (parse_result),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_result)
    );

    assign m_axis_tdata    = out_result.pose_bytes;
    assign m_axis_tuser[0] = out_result.frame_ok;

endmodule

/* rtl/slxfr_cfg_regs.sv */
// ----------------------------------------------------------------------------
// slxfr_cfg_regs
// Sync byte registers written through the configuration channel.
// ----------------------------------------------------------------------------
module slxfr_cfg_regs
    import slxfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  logic [1:0] wr_index,
    input  logic [7:0] wr_data,
    output sync_cfg_t  sync_cfg
);

    sync_cfg_t sync_reg;
    sync_cfg_t sync_next;

    always_comb
    begin
        sync_next = sync_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_SYNC_ONE:   sync_next.one   = wr_data;
                CFG_SYNC_TWO:   sync_next.two   = wr_data;
                CFG_SYNC_THREE: sync_next.three = wr_data;
                default:        sync_next       = sync_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg.one   <= SYNC_ONE_RESET;
            sync_reg.two   <= SYNC_TWO_RESET;
            sync_reg.three <= SYNC_THREE_RESET;
        end
        else
        begin
            sync_reg <= sync_next;
        end
    end

    assign sync_cfg = sync_reg;

endmodule

/* rtl/slxfr_parser.sv */
// ----------------------------------------------------------------------------
// slxfr_parser
// Per-byte frame state: sync hunt, length check, checksum, payload capture.
// ----------------------------------------------------------------------------
module slxfr_parser
    import slxfr_pkg::*;
#(
    parameter int FRAME_BUFFER_BYTES = DEF_FRAME_BUFFER_BYTES,
    parameter int POSE_BYTE_COUNT    = DEF_POSE_BYTE_COUNT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  sync_cfg_t sync_cfg,
    input  logic      step,
    input  logic [7:0] rx_byte,
    output logic      produce,
    output result_t   result
);

    localparam int PW  = $clog2(FRAME_BUFFER_BYTES + 1);
    localparam int PW1 = PW + 1;
    localparam int LW  = $clog2(FRAME_BUFFER_BYTES - HEADER_BYTES + 1);
    localparam int CW  = 8 * POSE_BYTE_COUNT;
    localparam logic [7:0] MAX_LEN = 8'(FRAME_BUFFER_BYTES - HEADER_BYTES);

    logic [PW-1:0]     pos_reg,  pos_next;
    logic [LW-1:0]     len_reg,  len_next;
    logic [7:0]        chk_reg,  chk_next;
    logic [7:0]        xor_reg,  xor_next;
    logic [CW-1:0]     cap_reg,  cap_next;
    logic [POSE_W-1:0] pose_reg, pose_next;

    logic [PW-1:0]     pos;
    logic [7:0]        chk_eff;
    logic [7:0]        xor_eff;
    logic [CW-1:0]     cap_eff;
    logic [63:0]       cap_ext;
    logic              frame_end;
    logic              ok;

    always_comb
    begin
        pos       = pos_reg + PW'(1);
        pos_next  = pos_reg;
        len_next  = len_reg;
        chk_next  = chk_reg;
        xor_next  = xor_reg;
        cap_next  = cap_reg;
        pose_next = pose_reg;
        chk_eff   = chk_reg;
        xor_eff   = xor_reg;
        cap_eff   = cap_reg;
        cap_ext   = 64'(cap_reg);
        frame_end = 1'b0;
        ok        = 1'b0;
        produce   = 1'b0;
        result.frame_ok   = 1'b0;
        result.pose_bytes = pose_reg;

        if (pos == PW'(1))
        begin
            pos_next = (rx_byte == sync_cfg.one) ? PW'(1) : '0;
        end
        else if (pos == PW'(2))
        begin
            pos_next = (rx_byte == sync_cfg.two) ? PW'(2) : '0;
        end
        else if (pos == PW'(3))
        begin
            pos_next = (rx_byte == sync_cfg.three) ? PW'(3) : '0;
        end
        else if (pos == PW'(HEADER_BYTES))
        begin
            if (rx_byte == 8'd0 || rx_byte > MAX_LEN)
            begin
                pos_next = '0;
            end
            else
            begin
                len_next = LW'(rx_byte);
                xor_next = 8'd0;
                pos_next = PW'(HEADER_BYTES);
            end
        end
        else
        begin
            if (pos == PW'(HEADER_BYTES + 1))
            begin
                chk_eff = rx_byte;
            end
            else
            begin
                xor_eff = xor_reg ^ rx_byte;
                for (int i = 0; i < POSE_BYTE_COUNT; i++)
                begin
                    if (pos == PW'(i + HEADER_BYTES + 2))
                    begin
                        cap_eff[8*i +: 8] = rx_byte;
                    end
                end
            end
            chk_next = chk_eff;
            xor_next = xor_eff;
            cap_next = cap_eff;
            cap_ext  = 64'(cap_eff);

            frame_end = PW1'(pos) >= (PW1'(len_reg) + PW1'(HEADER_BYTES));
            if (frame_end)
            begin
                ok        = (chk_eff == xor_eff);
                produce   = 1'b1;
                pose_next = ok ? cap_ext[POSE_W-1:0] : pose_reg;
                result.frame_ok   = ok;
                result.pose_bytes = pose_next;
                pos_next  = '0;
                len_next  = LW'(1);
            end
            else
            begin
                pos_next = pos;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            len_reg  <= LW'(1);
            chk_reg  <= '0;
            xor_reg  <= '0;
            cap_reg  <= '0;
            pose_reg <= '0;
        end
        else if (step)
        begin
            pos_reg  <= pos_next;
            len_reg  <= len_next;
            chk_reg  <= chk_next;
            xor_reg  <= xor_next;
            cap_reg  <= cap_next;
            pose_reg <= pose_next;
        end
    end

endmodule

/* rtl/slxfr_out_stage.sv */
// ----------------------------------------------------------------------------
// slxfr_out_stage
// Result register holding one frame result until the sink takes it.
// ----------------------------------------------------------------------------
module slxfr_out_stage
    import slxfr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/slxfr_checker.sv */
// ----------------------------------------------------------------------------
// slxfr_checker
// Port-level checks for the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module slxfr_checker
    import slxfr_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [POSE_W-1:0] m_axis_tdata,
    input logic [0:0]        m_axis_tuser,
    input logic              cfg_valid,
    input logic              cfg_ready
);

    // a held result keeps its valid and payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // a fresh result comes from an item taken earlier, through the input and result registers
    a_out_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a matching input item");

    // input backpressure only comes from a stalled output
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled while output free");

    // configuration channel never pushes back
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind sync_length_xor_frame_receiver slxfr_checker u_slxfr_checker (.*);
